[rtl/dgt_pkg.sv]
// shared types and constants of the directed graph table
package dgt_pkg;

  localparam int unsigned DefMaxNodes = 16;
  localparam int unsigned DefKeyBits  = 16;
  localparam int unsigned InKeyW      = 16;
  localparam int unsigned OpW         = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned SlotOutW    = 4;
  localparam int unsigned CntW        = 5;
  localparam logic [CntW-1:0] CntMax  = {CntW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OP_SEARCH_NODE = 3'd0,
    OP_SEARCH_EDGE = 3'd1,
    OP_INSERT_NODE = 3'd2,
    OP_INSERT_EDGE = 3'd3,
    OP_DELETE_NODE = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_PRESENT   = 2'd3
  } status_e;

endpackage

[rtl/dgt_req_if.sv]
// request channel of the directed graph table
interface dgt_req_if
  import dgt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           operation;
  logic signed [InKeyW-1:0] node_key;
  logic signed [InKeyW-1:0] target_key;

  modport source (output valid, operation, node_key, target_key, input ready);
  modport sink   (input valid, operation, node_key, target_key, output ready);
endinterface

[rtl/dgt_rsp_if.sv]
// response channel of the directed graph table
interface dgt_rsp_if
  import dgt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [SlotOutW-1:0] slot_index;
  logic [CntW-1:0]     incoming_count;

  modport source (output valid, status, slot_index, incoming_count, input ready);
  modport sink   (input valid, status, slot_index, incoming_count, output ready);
endinterface

[rtl/dgt_cell.sv]
// one node slot: holds its state and passes the lookup probe to the next slot
module dgt_cell
  import dgt_pkg::*;
#(
  parameter int unsigned MAX_NODES = DefMaxNodes,
  parameter int unsigned KEY_BITS  = DefKeyBits,
  parameter int unsigned IDX       = 0,
  localparam int unsigned SW       = $clog2(MAX_NODES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // probe keys
  input  logic [KEY_BITS-1:0]  key_a_i,
  input  logic [KEY_BITS-1:0]  key_b_i,
  // probe from the previous slot
  input  logic                 fa_ok_i,
  input  logic [SW-1:0]        fa_slot_i,
  input  logic                 fb_ok_i,
  input  logic [SW-1:0]        fb_slot_i,
  input  logic                 f1_ok_i,
  input  logic [SW-1:0]        f1_slot_i,
  input  logic                 f2_ok_i,
  input  logic [SW-1:0]        f2_slot_i,
  input  logic [MAX_NODES-1:0] row_a_i,
  input  logic [CntW-1:0]      cnt_a_i,
  input  logic [CntW-1:0]      cnt_b_i,
  // probe to the next slot
  output logic                 fa_ok_o,
  output logic [SW-1:0]        fa_slot_o,
  output logic                 fb_ok_o,
  output logic [SW-1:0]        fb_slot_o,
  output logic                 f1_ok_o,
  output logic [SW-1:0]        f1_slot_o,
  output logic                 f2_ok_o,
  output logic [SW-1:0]        f2_slot_o,
  output logic [MAX_NODES-1:0] row_a_o,
  output logic [CntW-1:0]      cnt_a_o,
  output logic [CntW-1:0]      cnt_b_o,
  // update command, broadcast to all slots
  input  logic                 al1_en_i,
  input  logic [SW-1:0]        al1_slot_i,
  input  logic [KEY_BITS-1:0]  al1_key_i,
  input  logic                 al2_en_i,
  input  logic [SW-1:0]        al2_slot_i,
  input  logic [KEY_BITS-1:0]  al2_key_i,
  input  logic                 set_en_i,
  input  logic [SW-1:0]        set_src_i,
  input  logic [SW-1:0]        set_dst_i,
  input  logic                 del_en_i,
  input  logic [SW-1:0]        del_slot_i,
  input  logic [MAX_NODES-1:0] del_row_i
);

  localparam logic [SW-1:0] Me = SW'(IDX);

  logic                 used_q, used_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [MAX_NODES-1:0] row_q, row_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 hit_a, hit_b;

  assign hit_a = used_q && (key_q == key_a_i);
  assign hit_b = used_q && (key_q == key_b_i);

  // probe stage
  always_ff @(posedge clk_i) begin
    fa_ok_o   <= fa_ok_i | hit_a;
    fa_slot_o <= (!fa_ok_i && hit_a) ? Me : fa_slot_i;
    row_a_o   <= (!fa_ok_i && hit_a) ? row_q : row_a_i;
    cnt_a_o   <= (!fa_ok_i && hit_a) ? cnt_q : cnt_a_i;
    fb_ok_o   <= fb_ok_i | hit_b;
    fb_slot_o <= (!fb_ok_i && hit_b) ? Me : fb_slot_i;
    cnt_b_o   <= (!fb_ok_i && hit_b) ? cnt_q : cnt_b_i;
    f1_ok_o   <= f1_ok_i | !used_q;
    f1_slot_o <= (!f1_ok_i && !used_q) ? Me : f1_slot_i;
    f2_ok_o   <= f2_ok_i | (f1_ok_i && !used_q);
    f2_slot_o <= (f1_ok_i && !f2_ok_i && !used_q) ? Me : f2_slot_i;
  end

  // state update
  always_comb begin
    used_d = used_q;
    key_d  = key_q;
    row_d  = row_q;
    cnt_d  = cnt_q;
    if (al1_en_i && al1_slot_i == Me) begin
      used_d = 1'b1;
      key_d  = al1_key_i;
      row_d  = '0;
      cnt_d  = '0;
    end
    if (al2_en_i && al2_slot_i == Me) begin
      used_d = 1'b1;
      key_d  = al2_key_i;
      row_d  = '0;
      cnt_d  = '0;
    end
    if (set_en_i && set_src_i == Me) begin
      row_d[set_dst_i] = 1'b1;
    end
    if (set_en_i && set_dst_i == Me && cnt_d != CntMax) begin
      cnt_d = cnt_d + 1'b1;
    end
    if (del_en_i) begin
      row_d[del_slot_i] = 1'b0;
      if (del_slot_i == Me) begin
        used_d = 1'b0;
        row_d  = '0;
        cnt_d  = '0;
      end else if (del_row_i[IDX] && cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      row_q  <= '0;
      cnt_q  <= '0;
    end else begin
      used_q <= used_d;
      row_q  <= row_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[rtl/directed_graph_table.sv]
// top level of the directed graph table: slot chain, sequencer and result register
// The accepting edge latches the request, then the S_PROBE state walks the lookup probe
// along the row of slot cells (one slot per cycle, collecting both key matches, the first two
// free slots, the source row and the counts), and the S_APPLY state broadcasts the update
// to the cells and loads the result beat together, once the result register is free. The
// next request is accepted after the sequencer has returned to S_IDLE. A new request is
// taken once the previous one has left the chain, even while its result beat is still
// waiting on the response channel; the update step waits only if an older result beat is
// still held. Keys are compared on their low KEY_BITS bits (sign extended from 16 bits
// when KEY_BITS is wider). No clearing pass follows reset.
module directed_graph_table
  import dgt_pkg::*;
#(
  parameter int unsigned MAX_NODES = DefMaxNodes,
  parameter int unsigned KEY_BITS  = DefKeyBits
) (
  input logic     clk_i,
  input logic     rst_ni,
  dgt_req_if.sink req_i,
  dgt_rsp_if.source rsp_o
);

  localparam int unsigned SW = $clog2(MAX_NODES);
  localparam logic [SW-1:0] LastIdx = SW'(MAX_NODES - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [SW-1:0] cnt_q, cnt_d;

  // latched request
  logic [OpW-1:0]      op_q;
  logic [KEY_BITS-1:0] ka_q, kb_q;

  // probe chain, one entry per cell boundary
  logic                 fa_ok   [MAX_NODES+1];
  logic [SW-1:0]        fa_slot [MAX_NODES+1];
  logic                 fb_ok   [MAX_NODES+1];
  logic [SW-1:0]        fb_slot [MAX_NODES+1];
  logic                 f1_ok   [MAX_NODES+1];
  logic [SW-1:0]        f1_slot [MAX_NODES+1];
  logic                 f2_ok   [MAX_NODES+1];
  logic [SW-1:0]        f2_slot [MAX_NODES+1];
  logic [MAX_NODES-1:0] row_a   [MAX_NODES+1];
  logic [CntW-1:0]      cnt_a   [MAX_NODES+1];
  logic [CntW-1:0]      cnt_b   [MAX_NODES+1];

  // update command
  logic                 al1_en, al2_en, set_en, del_en;
  logic [SW-1:0]        al1_slot, al2_slot, set_src, set_dst;

  // decision
  logic                 fire_out;
  logic [StatusW-1:0]   res_status;
  logic [SW-1:0]        res_slot;
  logic [CntW-1:0]      res_cnt;
  logic                 new_a, new_b, a_ok, b_ok;
  logic [SW-1:0]        sa, sb;
  logic [CntW-1:0]      cb;

  // result register
  logic                 out_valid_q;
  logic [StatusW-1:0]   out_status_q;
  logic [SlotOutW-1:0]  out_slot_q;
  logic [CntW-1:0]      out_cnt_q;

  assign req_i.ready = (state_q == S_IDLE);

  // probe enters the chain empty
  assign fa_ok[0]   = 1'b0;
  assign fa_slot[0] = '0;
  assign fb_ok[0]   = 1'b0;
  assign fb_slot[0] = '0;
  assign f1_ok[0]   = 1'b0;
  assign f1_slot[0] = '0;
  assign f2_ok[0]   = 1'b0;
  assign f2_slot[0] = '0;
  assign row_a[0]   = '0;
  assign cnt_a[0]   = '0;
  assign cnt_b[0]   = '0;

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    dgt_cell #(
      .MAX_NODES (MAX_NODES),
      .KEY_BITS  (KEY_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_a_i    (ka_q),
      .key_b_i    (kb_q),
      .fa_ok_i    (fa_ok[i]),
      .fa_slot_i  (fa_slot[i]),
      .fb_ok_i    (fb_ok[i]),
      .fb_slot_i  (fb_slot[i]),
      .f1_ok_i    (f1_ok[i]),
      .f1_slot_i  (f1_slot[i]),
      .f2_ok_i    (f2_ok[i]),
      .f2_slot_i  (f2_slot[i]),
      .row_a_i    (row_a[i]),
      .cnt_a_i    (cnt_a[i]),
      .cnt_b_i    (cnt_b[i]),
      .fa_ok_o    (fa_ok[i+1]),
      .fa_slot_o  (fa_slot[i+1]),
      .fb_ok_o    (fb_ok[i+1]),
      .fb_slot_o  (fb_slot[i+1]),
      .f1_ok_o    (f1_ok[i+1]),
      .f1_slot_o  (f1_slot[i+1]),
      .f2_ok_o    (f2_ok[i+1]),
      .f2_slot_o  (f2_slot[i+1]),
      .row_a_o    (row_a[i+1]),
      .cnt_a_o    (cnt_a[i+1]),
      .cnt_b_o    (cnt_b[i+1]),
      .al1_en_i   (al1_en),
      .al1_slot_i (al1_slot),
      .al1_key_i  (ka_q),
      .al2_en_i   (al2_en),
      .al2_slot_i (al2_slot),
      .al2_key_i  (kb_q),
      .set_en_i   (set_en),
      .set_src_i  (set_src),
      .set_dst_i  (set_dst),
      .del_en_i   (del_en),
      .del_slot_i (fa_slot[MAX_NODES]),
      .del_row_i  (row_a[MAX_NODES])
    );
  end

  // the result beat and the update go out together once the result register is free
  assign fire_out = (state_q == S_APPLY) && (!out_valid_q || rsp_o.ready);

  // decision on the probe that has left the last cell
  always_comb begin
    al1_en     = 1'b0;
    al2_en     = 1'b0;
    set_en     = 1'b0;
    del_en     = 1'b0;
    al1_slot   = f1_slot[MAX_NODES];
    al2_slot   = f1_slot[MAX_NODES];
    set_src    = '0;
    set_dst    = '0;
    res_status = ST_NOT_FOUND;
    res_slot   = '0;
    res_cnt    = '0;
    new_a      = 1'b0;
    new_b      = 1'b0;
    a_ok       = 1'b0;
    b_ok       = 1'b0;
    sa         = '0;
    sb         = '0;
    cb         = '0;
    case (op_q)
      OP_SEARCH_NODE: begin
        if (fa_ok[MAX_NODES]) begin
          res_status = ST_OK;
          res_slot   = fa_slot[MAX_NODES];
          res_cnt    = cnt_a[MAX_NODES];
        end
      end
      OP_SEARCH_EDGE: begin
        if (fa_ok[MAX_NODES] && fb_ok[MAX_NODES] &&
            row_a[MAX_NODES][fb_slot[MAX_NODES]]) begin
          res_status = ST_OK;
          res_slot   = fb_slot[MAX_NODES];
          res_cnt    = cnt_b[MAX_NODES];
        end
      end
      OP_INSERT_NODE: begin
        if (fa_ok[MAX_NODES]) begin
          res_status = ST_PRESENT;
          res_slot   = fa_slot[MAX_NODES];
          res_cnt    = cnt_a[MAX_NODES];
        end else if (f1_ok[MAX_NODES]) begin
          al1_en     = 1'b1;
          res_status = ST_OK;
          res_slot   = f1_slot[MAX_NODES];
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_INSERT_EDGE: begin
        // source endpoint
        if (fa_ok[MAX_NODES]) begin
          a_ok = 1'b1;
          sa   = fa_slot[MAX_NODES];
        end else if (f1_ok[MAX_NODES]) begin
          a_ok  = 1'b1;
          new_a = 1'b1;
          sa    = f1_slot[MAX_NODES];
        end
        // target endpoint, same slot for a self loop
        if (ka_q == kb_q) begin
          b_ok = a_ok;
          sb   = sa;
          cb   = new_a ? '0 : cnt_a[MAX_NODES];
        end else if (fb_ok[MAX_NODES]) begin
          b_ok = 1'b1;
          sb   = fb_slot[MAX_NODES];
          cb   = cnt_b[MAX_NODES];
        end else if (new_a) begin
          b_ok     = f2_ok[MAX_NODES];
          new_b    = 1'b1;
          sb       = f2_slot[MAX_NODES];
          al2_slot = f2_slot[MAX_NODES];
        end else begin
          b_ok  = f1_ok[MAX_NODES];
          new_b = 1'b1;
          sb    = f1_slot[MAX_NODES];
        end
        al1_en = new_a;
        if (!a_ok) begin
          res_status = ST_FULL;
        end else if (!b_ok) begin
          // a freshly added source stays in the table
          res_status = ST_FULL;
        end else begin
          al2_en = new_b;
          res_slot = sb;
          if (!new_a && !new_b && row_a[MAX_NODES][sb]) begin
            res_status = ST_PRESENT;
            res_cnt    = cb;
          end else begin
            set_en     = 1'b1;
            set_src    = sa;
            set_dst    = sb;
            res_status = ST_OK;
            res_cnt    = (cb == CntMax) ? cb : cb + 1'b1;
          end
        end
      end
      OP_DELETE_NODE: begin
        if (fa_ok[MAX_NODES]) begin
          del_en     = 1'b1;
          res_status = ST_OK;
          res_slot   = fa_slot[MAX_NODES];
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
    // commands only leave when the result beat does
    if (!fire_out) begin
      al1_en = 1'b0;
      al2_en = 1'b0;
      set_en = 1'b0;
      del_en = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_PROBE;
          cnt_d   = '0;
        end
      end
      S_PROBE: begin
        // probe reaches the end of the chain when the counter reaches the last slot
        if (cnt_q == LastIdx) begin
          state_d = S_APPLY;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_APPLY: begin
        if (fire_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // request latch, keys taken on their low bits with sign extension when wider
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q <= req_i.operation;
      ka_q <= KEY_BITS'({{32{req_i.node_key[InKeyW-1]}}, req_i.node_key});
      kb_q <= KEY_BITS'({{32{req_i.target_key[InKeyW-1]}}, req_i.target_key});
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_out) begin
      out_status_q <= res_status;
      out_slot_q   <= SlotOutW'(res_slot);
      out_cnt_q    <= res_cnt;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.slot_index     = out_slot_q;
  assign rsp_o.incoming_count = out_cnt_q;

  // an accepted request always starts a probe
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_PROBE && cnt_q == '0))
    else $error("accepted request did not start a probe");

  // a fresh result beat only comes out of the update step
  a_beat_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !$past(rsp_o.valid)) |-> $past(state_q == S_APPLY))
    else $error("result beat raised outside the update step");

  // slot updates never issue while the result register is blocked
  a_cmd_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (al1_en || al2_en || set_en || del_en) |-> fire_out)
    else $error("update issued without a result beat");

  // the probe counter stays inside the chain
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (cnt_q <= LastIdx))
    else $error("probe counter beyond last slot");

endmodule

[tb/tb_dgt_chan.sv]
// testbench channel interfaces are those of the rtl; this file holds the beat record type
`timescale 1ns / 1ps
package tb_dgt_pkg;
  import dgt_pkg::*;

  typedef struct packed {
    op_e              operation;
    logic signed [15:0] node_key;
    logic signed [15:0] target_key;
  } req_beat_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot_index;
    logic [4:0] incoming_count;
  } rsp_beat_t;
endpackage

[tb/tb_top.sv]
// testbench top: drives directed and random graph requests into the table and checks each result beat
`timescale 1ns / 1ps
module tb_top;
  import dgt_pkg::*;
  import tb_dgt_pkg::*;

  localparam int NODES = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  dgt_req_if req_if ();
  dgt_rsp_if rsp_if ();

  directed_graph_table DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  // shadow copy of the table
  logic        sh_used [NODES];
  logic [15:0] sh_key  [NODES];
  logic [15:0] sh_row  [NODES];
  logic [4:0]  sh_pred [NODES];

  req_beat_t pending_reqs[$];
  rsp_beat_t awaited_rsps[$];
  int fails = 0;
  int n_sent = 0, n_got = 0;
  int send_idle = 0, recv_idle = 0; // percent
  bit recv_hold = 0;
  bit send_pause = 0;
  bit req_taken;
  int keys_pool[8];

  function automatic int find_node(logic [15:0] k);
    for (int s = 0; s < NODES; s++) if (sh_used[s] && sh_key[s] == k) return s;
    return -1;
  endfunction

  function automatic int grab_slot(logic [15:0] k);
    for (int s = 0; s < NODES; s++)
      if (!sh_used[s]) begin
        sh_used[s] = 1; sh_key[s] = k; sh_row[s] = '0; sh_pred[s] = '0;
        return s;
      end
    return -1;
  endfunction

  function automatic rsp_beat_t mk_rsp(status_e st, int s);
    rsp_beat_t r;
    r.status = st;
    r.slot_index = (s < 0) ? '0 : s[3:0];
    r.incoming_count = (s < 0) ? '0 : sh_pred[s];
    return r;
  endfunction

  // apply one request to the shadow table and return its result
  function automatic rsp_beat_t graph_apply(req_beat_t q);
    int sa, sb;
    logic [15:0] a, b;
    a = q.node_key; b = q.target_key;
    case (q.operation)
      OP_SEARCH_NODE: begin
        sa = find_node(a);
        return mk_rsp(sa < 0 ? ST_NOT_FOUND : ST_OK, sa);
      end
      OP_SEARCH_EDGE: begin
        sa = find_node(a); sb = find_node(b);
        if (sa >= 0 && sb >= 0 && sh_row[sa][sb]) return mk_rsp(ST_OK, sb);
        return mk_rsp(ST_NOT_FOUND, -1);
      end
      OP_INSERT_NODE: begin
        sa = find_node(a);
        if (sa >= 0) return mk_rsp(ST_PRESENT, sa);
        sa = grab_slot(a);
        return (sa < 0) ? mk_rsp(ST_FULL, -1) : mk_rsp(ST_OK, sa);
      end
      OP_INSERT_EDGE: begin
        sa = find_node(a);
        if (sa < 0) sa = grab_slot(a);
        if (sa < 0) return mk_rsp(ST_FULL, -1);
        sb = find_node(b);
        if (sb < 0) sb = grab_slot(b);
        if (sb < 0) return mk_rsp(ST_FULL, -1);
        if (sh_row[sa][sb]) return mk_rsp(ST_PRESENT, sb);
        sh_row[sa][sb] = 1'b1;
        if (sh_pred[sb] != 5'd31) sh_pred[sb]++;
        return mk_rsp(ST_OK, sb);
      end
      OP_DELETE_NODE: begin
        sa = find_node(a);
        if (sa < 0) return mk_rsp(ST_NOT_FOUND, -1);
        for (int s = 0; s < NODES; s++) begin
          if (s != sa && sh_row[sa][s] && sh_pred[s] != 0) sh_pred[s]--;
          sh_row[s][sa] = 1'b0;
        end
        sh_row[sa] = '0; sh_pred[sa] = '0; sh_used[sa] = 0;
        return mk_rsp(ST_OK, sa);
      end
      default: return mk_rsp(ST_NOT_FOUND, -1);
    endcase
  endfunction

  // request beat taken at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) req_taken <= 1'b0;
    else req_taken <= req_if.valid && req_if.ready;
  end

  // driver: new beat at the falling edge once the previous one was taken
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.operation <= '0;
      req_if.node_key <= '0;
      req_if.target_key <= '0;
    end else if (!req_if.valid || req_taken) begin
      if (pending_reqs.size() != 0 && !send_pause &&
          $urandom_range(99, 0) >= send_idle) begin
        req_beat_t q;
        q = pending_reqs.pop_front();
        req_if.valid <= 1'b1;
        req_if.operation <= q.operation;
        req_if.node_key <= q.node_key;
        req_if.target_key <= q.target_key;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver ready, long hold-off when asked
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= !recv_hold && ($urandom_range(99, 0) >= recv_idle);
  end

  // monitor: predict on request accept, compare on result accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        req_beat_t q;
        q.operation = op_e'(req_if.operation);
        q.node_key = req_if.node_key;
        q.target_key = req_if.target_key;
        awaited_rsps.push_back(graph_apply(q));
        n_sent++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        n_got++;
        if (awaited_rsps.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          rsp_beat_t e;
          e = awaited_rsps.pop_front();
          if (rsp_if.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, rsp_if.status); fails++;
          end
          if (rsp_if.slot_index !== e.slot_index) begin
            $error("slot_index expected %0d got %0d", e.slot_index, rsp_if.slot_index);
            fails++;
          end
          if (rsp_if.incoming_count !== e.incoming_count) begin
            $error("incoming_count expected %0d got %0d", e.incoming_count,
                   rsp_if.incoming_count);
            fails++;
          end
        end
      end
    end
  end

  task automatic push_req(op_e op, int a, int b);
    req_beat_t q;
    q.operation = op; q.node_key = a[15:0]; q.target_key = b[15:0];
    pending_reqs.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_if.valid || awaited_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  // random key: mostly from a small pool so nodes collide, sometimes anything
  function automatic int pick_key();
    if ($urandom_range(9, 0) == 0) return $urandom_range(65535, 0);
    return keys_pool[$urandom_range(7, 0)];
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      int r;
      op_e op;
      r = $urandom_range(99, 0);
      if (r < 15) op = OP_SEARCH_NODE;
      else if (r < 30) op = OP_SEARCH_EDGE;
      else if (r < 50) op = OP_INSERT_NODE;
      else if (r < 80) op = OP_INSERT_EDGE;
      else if (r < 97) op = OP_DELETE_NODE;
      else op = op_e'($urandom_range(7, 5));
      push_req(op, pick_key(), pick_key());
    end
  endtask

  initial begin
    int hold_cycles;
    for (int s = 0; s < NODES; s++) begin
      sh_used[s] = 0; sh_key[s] = '0; sh_row[s] = '0; sh_pred[s] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: extremes, self loop, edge adds on a full table, unknown codes
    push_req(OP_SEARCH_NODE, 0, 0);
    push_req(OP_INSERT_NODE, 32'h8000, 0);
    push_req(OP_INSERT_NODE, 32'h7fff, 0);
    push_req(OP_INSERT_NODE, 32'h7fff, 0);
    push_req(OP_INSERT_EDGE, 32'h8000, 32'h7fff);
    push_req(OP_INSERT_EDGE, 32'h8000, 32'h7fff);
    push_req(OP_SEARCH_EDGE, 32'h8000, 32'h7fff);
    push_req(OP_SEARCH_EDGE, 32'h7fff, 32'h8000);
    push_req(OP_INSERT_EDGE, 32'hffff, 32'hffff);
    push_req(OP_SEARCH_NODE, 32'hffff, 0);
    push_req(OP_DELETE_NODE, 32'h8000, 0);
    push_req(OP_SEARCH_NODE, 32'h7fff, 0);
    push_req(OP_DELETE_NODE, 32'h1234, 0);
    push_req(op_e'(3'd5), 1, 2);
    push_req(op_e'(3'd7), 32'hffff, 32'hffff);
    for (int k = 0; k < 15; k++) push_req(OP_INSERT_NODE, 100 + k, 0);
    push_req(OP_INSERT_NODE, 999, 0);
    push_req(OP_INSERT_EDGE, 100, 555);
    push_req(OP_INSERT_EDGE, 777, 888);
    wait_drained();

    // idle pattern phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 16 : (ph == 1) ? 51 : 0;
      recv_idle = (ph == 0) ? 51 : (ph == 1) ? 16 : 0;
      for (int i = 0; i < 8; i++) keys_pool[i] = $urandom_range(65535, 0);
      keys_pool[0] = 0; keys_pool[1] = 32'hffff;
      random_phase(500);
      if (ph == 1) begin
        // receiver stalls long while requests keep coming
        hold_cycles = 0;
        recv_hold = 1;
        while (hold_cycles < 300) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        recv_hold = 0;
      end
      wait_drained();
      // sender pause until everything is back
      send_pause = 1;
      wait_drained();
      send_pause = 0;
    end
    random_phase(130);
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d requests and %0d results over three idle patterns", n_sent, n_got);
    if (fails == 0 && awaited_rsps.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
